>>> src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: per-symbol trade statistics shared definitions
// Request codes, table entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int unsigned SYMBOL_SLOTS_DEF = 256;
    localparam int unsigned SYM_W            = 8;
    localparam int unsigned SYM_CODES        = 2 ** SYM_W;
    localparam int unsigned PX_W             = 32;
    localparam int unsigned QTY_W            = 32;
    localparam int unsigned VOL_W            = 48;
    localparam int unsigned CNT_W            = 32;
    localparam int unsigned SUM_W            = 64;
    localparam int unsigned OP_W             = 2;
    localparam int unsigned S_DATA_W         = 80;
    localparam int unsigned M_DATA_W         = 432;

    typedef enum logic [OP_W-1:0] {
        OP_TRADE = 2'd0,
        OP_TOUCH = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic             valid;
        logic [PX_W-1:0]  open_px;
        logic [PX_W-1:0]  high_px;
        logic [PX_W-1:0]  low_px;
        logic [PX_W-1:0]  last_px;
        logic [VOL_W-1:0] total_volume;
        logic [CNT_W-1:0] total_trades;
        logic [SUM_W-1:0] weighted_sum;
        logic [VOL_W-1:0] buy_volume;
        logic [VOL_W-1:0] sell_volume;
        logic [CNT_W-1:0] buy_trades;
        logic [CNT_W-1:0] sell_trades;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load_req;
        logic sweep_wr;
        logic rd_en;
        logic latch_ent;
        logic wr_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        op_t  req_op;
        logic sweep_last;
        logic out_free;
    } stat_t;

endpackage

>>> src/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl: request sequencer
// Walks each request through table read, update and write-back, and runs
// the table clearing sweep after reset and on a clear request.
// ----------------------------------------------------------------------------
module pst_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pst_pkg::stat_t stat,
    output pst_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        CLR_INIT,
        CLR_OP,
        IDLE,
        READ,
        FETCH,
        UPDATE,
        ZERO
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            CLR_INIT: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = IDLE;
                end
            end
            CLR_OP: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ZERO;
                end
            end
            IDLE: begin
                if (accept) begin
                    cmd.load_req = 1'b1;
                    state_next = (stat.in_op == pst_pkg::OP_CLEAR) ? CLR_OP : READ;
                end
            end
            READ: begin
                cmd.rd_en  = 1'b1;
                state_next = FETCH;
            end
            FETCH: begin
                cmd.latch_ent = 1'b1;
                state_next    = UPDATE;
            end
            UPDATE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.wr_en    = (stat.req_op == pst_pkg::OP_TRADE) ||
                                   (stat.req_op == pst_pkg::OP_TOUCH);
                    state_next   = IDLE;
                end
            end
            ZERO: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = CLR_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLR_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/pst_datapath.sv
// ----------------------------------------------------------------------------
// pst_datapath: statistics table and update arithmetic
// Holds the request, the symbol table RAM, the entry update logic and the
// result register.
// ----------------------------------------------------------------------------
module pst_datapath #(
    parameter int unsigned SYMBOL_SLOTS = pst_pkg::SYMBOL_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pst_pkg::OP_W-1:0]      s_tuser,
    input  logic [pst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pst_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    input  pst_pkg::cmd_t                 cmd,
    output pst_pkg::stat_t                stat
);

    localparam int unsigned AW = $clog2(SYMBOL_SLOTS);
    localparam int unsigned PX_W  = pst_pkg::PX_W;
    localparam int unsigned VOL_W = pst_pkg::VOL_W;
    localparam int unsigned CNT_W = pst_pkg::CNT_W;
    localparam int unsigned SUM_W = pst_pkg::SUM_W;

    // symbol code to table slot, reduced modulo the table size
    logic [AW-1:0] slot_tab [pst_pkg::SYM_CODES];
    for (genvar i = 0; i < pst_pkg::SYM_CODES; i++) begin : g_slot
        localparam int unsigned SLOT_VAL = i % SYMBOL_SLOTS;
        assign slot_tab[i] = SLOT_VAL[AW-1:0];
    end

    function automatic logic [VOL_W-1:0] sat_add_vol(logic [VOL_W-1:0] a,
                                                     logic [pst_pkg::QTY_W-1:0] b);
        logic [VOL_W:0] s;
        s = {1'b0, a} + {{(VOL_W + 1 - pst_pkg::QTY_W){1'b0}}, b};
        return s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a);
        return (&a) ? a : a + CNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add_sum(logic [SUM_W-1:0] a,
                                                     logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // request register
    pst_pkg::op_t                req_op_reg;
    logic [AW-1:0]               req_slot_reg;
    logic [PX_W-1:0]             req_px_reg;
    logic [pst_pkg::QTY_W-1:0]   req_qty_reg;
    logic                        req_buy_reg;

    logic [AW-1:0]               sweep_cnt_reg;
    pst_pkg::entry_t             ent_reg;
    logic [SUM_W-1:0]            prod_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [pst_pkg::M_DATA_W-1:0] out_data_reg;
    logic                        out_known_reg;

    logic [pst_pkg::ENTRY_W-1:0] ram_rdata;
    logic [pst_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_waddr;
    pst_pkg::entry_t             rd_ent;
    pst_pkg::entry_t             base, upd;
    logic                        out_known;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_op_reg   <= pst_pkg::op_t'(s_tuser);
            req_slot_reg <= slot_tab[s_tdata[pst_pkg::SYM_W-1:0]];
            req_px_reg   <= s_tdata[39:8];
            req_qty_reg  <= s_tdata[71:40];
            req_buy_reg  <= s_tdata[72];
        end
        if (cmd.latch_ent) begin
            ent_reg  <= rd_ent;
            prod_reg <= SUM_W'(req_px_reg) * SUM_W'(req_qty_reg);
        end
        if (cmd.load_out) begin
            out_known_reg <= out_known;
            out_data_reg  <= out_known ?
                {upd.sell_trades, upd.buy_trades, upd.sell_volume, upd.buy_volume,
                 upd.weighted_sum, upd.total_trades, upd.total_volume,
                 upd.last_px, upd.low_px, upd.high_px, upd.open_px} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_req) begin
            sweep_cnt_reg <= '0;
        end else if (cmd.sweep_wr) begin
            sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
        end
    end

    assign m_tvalid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign rd_ent = pst_pkg::entry_t'(ram_rdata);

    // new entry: create on first trade or touch, then fold in a trade
    always_comb begin
        base = ent_reg;
        if (!ent_reg.valid) begin
            base         = '0;
            base.valid   = 1'b1;
            base.open_px = req_px_reg;
            base.high_px = req_px_reg;
            base.low_px  = req_px_reg;
            base.last_px = req_px_reg;
        end
        upd = base;
        if (req_op_reg == pst_pkg::OP_TRADE) begin
            if (req_px_reg > base.high_px) begin
                upd.high_px = req_px_reg;
            end
            if (req_px_reg < base.low_px) begin
                upd.low_px = req_px_reg;
            end
            upd.last_px      = req_px_reg;
            upd.total_volume = sat_add_vol(base.total_volume, req_qty_reg);
            upd.total_trades = sat_inc(base.total_trades);
            upd.weighted_sum = sat_add_sum(base.weighted_sum, prod_reg);
            if (req_buy_reg) begin
                upd.buy_volume = sat_add_vol(base.buy_volume, req_qty_reg);
                upd.buy_trades = sat_inc(base.buy_trades);
            end else begin
                upd.sell_volume = sat_add_vol(base.sell_volume, req_qty_reg);
                upd.sell_trades = sat_inc(base.sell_trades);
            end
        end else if (req_op_reg == pst_pkg::OP_QUERY ||
                     req_op_reg == pst_pkg::OP_CLEAR) begin
            upd = ent_reg;
        end
    end

    assign out_known = upd.valid && (req_op_reg != pst_pkg::OP_CLEAR);

    // sweep writes an empty entry; valid=0 marks the slot unknown
    assign ram_waddr = cmd.sweep_wr ? sweep_cnt_reg : req_slot_reg;
    assign ram_wdata = cmd.sweep_wr ? '0 : pst_pkg::ENTRY_W'(upd);

    pst_ram #(
        .WIDTH (pst_pkg::ENTRY_W),
        .DEPTH (SYMBOL_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.sweep_wr || cmd.wr_en),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (req_slot_reg),
        .rdata (ram_rdata)
    );

    assign stat.in_op      = pst_pkg::op_t'(s_tuser);
    assign stat.req_op     = req_op_reg;
    assign stat.sweep_last = (sweep_cnt_reg == AW'(SYMBOL_SLOTS - 1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_known_reg;

endmodule

>>> src/per_symbol_trade_stats.sv
// ----------------------------------------------------------------------------
// per_symbol_trade_stats: per-symbol OHLCV / VWAP statistics table
// Each request (trade, order touch, query, clear all) returns one result:
// the symbol's entry after the step. An unseen symbol is created on its
// first trade or touch; totals saturate at their maximum.
// Input s_*: tuser carries the request code, tdata the symbol index, price,
// quantity and aggressor side. Output m_*: tuser is the known flag, tdata
// the entry fields; an unknown symbol or a clear returns all zeros.
// Timing: a table request goes through RAM read, entry latch with registered
// multiply, and update and write-back into the result register, in a
// single read-modify-write pass over the table RAM; a new request is taken
// only once the previous one has loaded the result register. A clear
// request sweeps every table slot and then returns its result.
// Reset: aresetn clears control and starts the same table sweep; s_tready
// stays low until it ends.
// Stall: the result register holds while m_tready is low; one more request
// may be accepted and waits at write-back until the result register frees.
// ----------------------------------------------------------------------------
module per_symbol_trade_stats #(
    parameter int unsigned SYMBOL_SLOTS = pst_pkg::SYMBOL_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [7:0] symbol_index, [39:8] price, [71:40] quantity, [72] buyer_aggressor
    input  logic [pst_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [pst_pkg::OP_W-1:0]     s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] open_px, [63:32] high_px, [95:64] low_px, [127:96] last_px,
    // [175:128] total_volume, [207:176] total_trades, [271:208] weighted_sum,
    // [319:272] buy_volume, [367:320] sell_volume, [399:368] buy_trades,
    // [431:400] sell_trades
    output logic [pst_pkg::M_DATA_W-1:0] m_tdata,
    // [0] known
    output logic                         m_tuser
);

    pst_pkg::cmd_t  cmd;
    pst_pkg::stat_t stat;

    pst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pst_datapath #(
        .SYMBOL_SLOTS (SYMBOL_SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
